// ===== hdl/cnft_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cnft_pkg
// Shared sizes, codes and link structures of the n-gram frequency table.
// ----------------------------------------------------------------------------
package cnft_pkg;

	localparam int MAX_GRAM_BYTES = 8;
	localparam int TABLE_DEPTH    = 1024;
	localparam int COUNT_BITS     = 32;
	// table entries are spread over the cells, entry i lives in cell i % NUM_CELLS
	localparam int NUM_CELLS      = 8;

	localparam int BYTE_W  = 8;
	localparam int FUNC_W  = 2;
	localparam int LEN_W   = 4;
	localparam int GRAM_W  = BYTE_W * MAX_GRAM_BYTES;
	localparam int INDEX_W = $clog2(TABLE_DEPTH);
	localparam int USED_W  = $clog2(TABLE_DEPTH + 1);
	localparam int CELL_W  = $clog2(NUM_CELLS);
	localparam int ROW_W   = INDEX_W - CELL_W;
	localparam int ROWS    = TABLE_DEPTH / NUM_CELLS;
	localparam int FILL_W  = $clog2(MAX_GRAM_BYTES + 1);

	localparam int S_TDATA_W = ((BYTE_W + INDEX_W + 7) / 8) * 8;
	localparam int M_TDATA_W = ((INDEX_W + COUNT_BITS + GRAM_W + USED_W + 7) / 8) * 8;
	localparam int M_TUSER_W = 3;

	// result flag positions in m_axis_tuser
	localparam int FLAG_WF  = 0;
	localparam int FLAG_NEW = 1;
	localparam int FLAG_TF  = 2;

	// result field positions in m_axis_tdata
	localparam int FI_LSB    = 0;
	localparam int CNT_LSB   = INDEX_W;
	localparam int BYTES_LSB = INDEX_W + COUNT_BITS;
	localparam int USED_LSB  = BYTES_LSB + GRAM_W;

	localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(3);

	typedef enum logic [FUNC_W-1:0] {
		FUNC_PUSH    = 2'd0,
		FUNC_READ    = 2'd1,
		FUNC_ZERO    = 2'd2,
		FUNC_RESTART = 2'd3
	} func_t;

	// probe token travelling down the chain, one row per token
	typedef struct packed {
		logic                  valid;
		logic                  last;
		logic                  by_index;
		logic [ROW_W-1:0]      row;
		logic                  hit;
		logic [INDEX_W-1:0]    hit_idx;
		logic [GRAM_W-1:0]     hit_key;
		logic [COUNT_BITS-1:0] hit_cnt;
	} tok_t;

	// what every cell compares against during one operation
	typedef struct packed {
		logic [GRAM_W-1:0]  key;
		logic [INDEX_W-1:0] idx;
		logic [USED_W-1:0]  used;
	} probe_t;

	// table write command, all selects every cell at the row
	typedef struct packed {
		logic                  en;
		logic                  all;
		logic                  key_en;
		logic [INDEX_W-1:0]    idx;
		logic [GRAM_W-1:0]     key;
		logic [COUNT_BITS-1:0] count;
	} wr_t;

endpackage

// ===== hdl/cnft_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cnft_cell
// One cell of the lookup chain: a bank of keys and counts, one compare stage.
// ----------------------------------------------------------------------------
module cnft_cell (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [cnft_pkg::CELL_W-1:0]  cell_id,
	input  cnft_pkg::probe_t             probe,
	input  cnft_pkg::wr_t                wr,
	input  cnft_pkg::tok_t               tok_in,
	output cnft_pkg::tok_t               tok_out
);

	logic [cnft_pkg::GRAM_W-1:0]     key_mem [cnft_pkg::ROWS];
	logic [cnft_pkg::COUNT_BITS-1:0] cnt_mem [cnft_pkg::ROWS];

	logic [cnft_pkg::GRAM_W-1:0]     rd_key_q;
	logic [cnft_pkg::COUNT_BITS-1:0] rd_cnt_q;
	cnft_pkg::tok_t                  tok_s1;
	logic                            tok_valid_s1;

	logic [cnft_pkg::ROW_W-1:0]      wr_row;
	logic                            wr_sel;
	logic [cnft_pkg::INDEX_W-1:0]    gidx;
	logic                            in_use;
	logic                            match;

	assign wr_row = wr.idx[cnft_pkg::INDEX_W-1:cnft_pkg::CELL_W];
	assign wr_sel = wr.en && (wr.all || (wr.idx[cnft_pkg::CELL_W-1:0] == cell_id));

	always_ff @(posedge clk) begin
		if (wr_sel) begin
			cnt_mem[wr_row] <= wr.count;
			if (wr.key_en) begin
				key_mem[wr_row] <= wr.key;
			end
		end
	end

	// registered read of the row carried by the incoming token
	always_ff @(posedge clk) begin
		rd_key_q <= key_mem[tok_in.row];
		rd_cnt_q <= cnt_mem[tok_in.row];
		tok_s1   <= tok_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_valid_s1 <= 1'b0;
		end else begin
			tok_valid_s1 <= tok_in.valid;
		end
	end

	assign gidx   = {tok_s1.row, cell_id};
	assign in_use = cnft_pkg::USED_W'(gidx) < probe.used;
	assign match  = in_use && (tok_s1.by_index ? (gidx == probe.idx) : (rd_key_q == probe.key));

	always_comb begin
		tok_out       = tok_s1;
		tok_out.valid = tok_valid_s1;
		if (tok_valid_s1 && match) begin
			tok_out.hit     = 1'b1;
			tok_out.hit_idx = gidx;
			tok_out.hit_key = rd_key_q;
			tok_out.hit_cnt = rd_cnt_q;
		end
	end

endmodule

// ===== hdl/char_ngram_frequency_table_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_ngram_frequency_table_core
// Counts character n-grams of a byte stream in a first-seen-order table.
// ----------------------------------------------------------------------------
// Each input word carries an operation in s_axis_tuser and gives exactly one
// result word on the master side. A push shifts a byte into the n-gram window
// (length from the configuration register, 0 acts as 1, above 8 acts as 8);
// once the window is full the n-gram is looked up, counted (saturating) or
// appended as a new entry, or dropped with table_full when all 1024 entries are
// taken. Read returns one entry, zero clears every count but keeps the keys,
// restart empties the window. The table is split over a chain of 8 cells, each
// owning every eighth entry in its own key and count bank; a lookup sends one
// token per used row down the chain and the token picks up the matching entry
// as it passes. One word is taken at a time. A push that completes an n-gram
// goes through row issue, the chain of cells, the count update or append and
// the output load, skipping the chain while the table is empty. A finished
// result waits for the output register while the previous result is stalled
// there. The next word is accepted while the last result still waits in the
// output register. Write the length register only while the block is idle;
// cfg_ready is always high.
// ----------------------------------------------------------------------------
module char_ngram_frequency_table_core (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration: ngram_length
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [cnft_pkg::LEN_W-1:0]      cfg_data,
	// input words
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [cnft_pkg::S_TDATA_W-1:0]  s_axis_tdata,  // data_byte, entry_index, zero pad
	input  logic [cnft_pkg::FUNC_W-1:0]     s_axis_tuser,  // func
	// result words
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [cnft_pkg::M_TDATA_W-1:0]  m_axis_tdata,  // found_index, gram_count,
	                                                       // gram_bytes, entries_used, zero pad
	output logic [cnft_pkg::M_TUSER_W-1:0]  m_axis_tuser   // window_full, is_new, table_full
);

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_SCAN   = 6'b000010,
		ST_WAIT   = 6'b000100,
		ST_DECIDE = 6'b001000,
		ST_ZERO   = 6'b010000,
		ST_DONE   = 6'b100000
	} state_t;

	state_t                          state_q;

	logic [cnft_pkg::LEN_W-1:0]      len_q;
	logic [cnft_pkg::GRAM_W-1:0]     win_q;
	logic [cnft_pkg::FILL_W-1:0]     fill_q;
	logic [cnft_pkg::USED_W-1:0]     used_q;
	logic [cnft_pkg::ROW_W-1:0]      iss_row_q;
	logic [cnft_pkg::ROW_W-1:0]      last_row_q;
	logic                            hit_q;
	logic [cnft_pkg::INDEX_W-1:0]    hit_idx_q;
	logic [cnft_pkg::GRAM_W-1:0]     hit_key_q;
	logic [cnft_pkg::COUNT_BITS-1:0] hit_cnt_q;
	logic [cnft_pkg::GRAM_W-1:0]     key_q;
	logic [cnft_pkg::INDEX_W-1:0]    tgt_q;
	logic                            mode_q;

	// pending result, then the output register
	logic [cnft_pkg::M_TUSER_W-1:0]  res_flags_q;
	logic [cnft_pkg::INDEX_W-1:0]    res_fi_q;
	logic [cnft_pkg::COUNT_BITS-1:0] res_cnt_q;
	logic [cnft_pkg::GRAM_W-1:0]     res_bytes_q;
	logic                            out_valid_q;
	logic [cnft_pkg::M_TUSER_W-1:0]  out_flags_q;
	logic [cnft_pkg::INDEX_W-1:0]    out_fi_q;
	logic [cnft_pkg::COUNT_BITS-1:0] out_cnt_q;
	logic [cnft_pkg::GRAM_W-1:0]     out_bytes_q;
	logic [cnft_pkg::USED_W-1:0]     out_used_q;

	logic                            accept;
	logic                            out_free;
	cnft_pkg::func_t                 in_func;
	logic [cnft_pkg::BYTE_W-1:0]     in_byte;
	logic [cnft_pkg::INDEX_W-1:0]    in_idx;
	logic [cnft_pkg::FILL_W-1:0]     eff_len;
	logic [cnft_pkg::GRAM_W-1:0]     len_mask;
	logic [cnft_pkg::GRAM_W-1:0]     push_win;
	logic [cnft_pkg::FILL_W-1:0]     push_fill;
	logic                            push_full;
	logic [cnft_pkg::USED_W-1:0]     used_m1;
	logic [cnft_pkg::ROW_W-1:0]      used_last_row;
	logic                            table_is_full;
	logic                            idx_in_range;
	logic [cnft_pkg::COUNT_BITS-1:0] inc_cnt;

	cnft_pkg::tok_t                  tok_link [cnft_pkg::NUM_CELLS+1];
	cnft_pkg::tok_t                  chain_out;
	cnft_pkg::probe_t                probe;
	cnft_pkg::wr_t                   wr;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;

	assign in_func = cnft_pkg::func_t'(s_axis_tuser);
	assign in_byte = s_axis_tdata[cnft_pkg::BYTE_W-1:0];
	assign in_idx  = s_axis_tdata[cnft_pkg::BYTE_W +: cnft_pkg::INDEX_W];

	// clamp the configured length into 1..MAX_GRAM_BYTES
	always_comb begin
		priority if (len_q == '0) begin
			eff_len = cnft_pkg::FILL_W'(1);
		end else if (len_q > cnft_pkg::LEN_W'(cnft_pkg::MAX_GRAM_BYTES)) begin
			eff_len = cnft_pkg::FILL_W'(cnft_pkg::MAX_GRAM_BYTES);
		end else begin
			eff_len = cnft_pkg::FILL_W'(len_q);
		end
	end

	always_comb begin
		for (int b = 0; b < cnft_pkg::MAX_GRAM_BYTES; b++) begin
			len_mask[b*cnft_pkg::BYTE_W +: cnft_pkg::BYTE_W] =
				{cnft_pkg::BYTE_W{cnft_pkg::FILL_W'(b) < eff_len}};
		end
	end

	// shift the byte in, keep only the n-gram bytes; fill drops to a shorter length
	assign push_win  = ((win_q << cnft_pkg::BYTE_W) | cnft_pkg::GRAM_W'(in_byte)) & len_mask;
	assign push_fill = (fill_q >= eff_len) ? eff_len : fill_q + cnft_pkg::FILL_W'(1);
	assign push_full = (push_fill == eff_len);

	assign used_m1       = used_q - cnft_pkg::USED_W'(1);
	assign used_last_row = used_m1[cnft_pkg::INDEX_W-1:cnft_pkg::CELL_W];
	assign table_is_full = (used_q == cnft_pkg::USED_W'(cnft_pkg::TABLE_DEPTH));
	assign idx_in_range  = (cnft_pkg::USED_W'(in_idx) < used_q);
	assign inc_cnt       = (hit_cnt_q == '1) ? hit_cnt_q : hit_cnt_q + cnft_pkg::COUNT_BITS'(1);

	// ---- chain of cells ----
	assign probe.key  = key_q;
	assign probe.idx  = tgt_q;
	assign probe.used = used_q;

	always_comb begin
		tok_link[0]          = '0;
		tok_link[0].valid    = (state_q == ST_SCAN);
		tok_link[0].last     = (iss_row_q == last_row_q);
		tok_link[0].by_index = mode_q;
		tok_link[0].row      = iss_row_q;
	end

	for (genvar c = 0; c < cnft_pkg::NUM_CELLS; c++) begin : g_cell
		cnft_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.cell_id (cnft_pkg::CELL_W'(c)),
			.probe   (probe),
			.wr      (wr),
			.tok_in  (tok_link[c]),
			.tok_out (tok_link[c+1])
		);
	end

	assign chain_out = tok_link[cnft_pkg::NUM_CELLS];

	// table writes: zero sweep hits every cell of a row, an update one entry
	always_comb begin
		wr = '0;
		if (state_q == ST_ZERO) begin
			wr.en  = 1'b1;
			wr.all = 1'b1;
			wr.idx = {iss_row_q, cnft_pkg::CELL_W'(0)};
		end else if ((state_q == ST_DECIDE) && !mode_q) begin
			if (hit_q) begin
				wr.en    = 1'b1;
				wr.idx   = hit_idx_q;
				wr.count = inc_cnt;
			end else if (!table_is_full) begin
				wr.en     = 1'b1;
				wr.key_en = 1'b1;
				wr.idx    = used_q[cnft_pkg::INDEX_W-1:0];
				wr.key    = key_q;
				wr.count  = cnft_pkg::COUNT_BITS'(1);
			end
		end
	end

	// ---- control ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			len_q       <= cnft_pkg::LEN_RESET;
			win_q       <= '0;
			fill_q      <= '0;
			used_q      <= '0;
			iss_row_q   <= '0;
			hit_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				len_q <= cfg_data;
			end
			// load a finished result, else drop the one taken by the receiver
			if ((state_q == ST_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			// collect the single matching entry as its token leaves the chain
			if (chain_out.valid && chain_out.hit) begin
				hit_q <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						hit_q <= 1'b0;
						unique case (in_func)
							cnft_pkg::FUNC_PUSH: begin
								win_q  <= push_win;
								fill_q <= push_fill;
								if (!push_full) begin
									state_q <= ST_DONE;
								end else if (used_q == '0) begin
									state_q <= ST_DECIDE;
								end else begin
									iss_row_q <= '0;
									state_q   <= ST_SCAN;
								end
							end
							cnft_pkg::FUNC_READ: begin
								if (idx_in_range) begin
									iss_row_q <= in_idx[cnft_pkg::INDEX_W-1:cnft_pkg::CELL_W];
									state_q   <= ST_SCAN;
								end else begin
									state_q <= ST_DONE;
								end
							end
							cnft_pkg::FUNC_ZERO: begin
								iss_row_q <= '0;
								state_q   <= (used_q == '0) ? ST_DONE : ST_ZERO;
							end
							cnft_pkg::FUNC_RESTART: begin
								win_q   <= '0;
								fill_q  <= '0;
								state_q <= ST_DONE;
							end
							default: state_q <= ST_DONE;
						endcase
					end
				end
				ST_SCAN: begin
					iss_row_q <= iss_row_q + cnft_pkg::ROW_W'(1);
					if (iss_row_q == last_row_q) begin
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					if (chain_out.valid && chain_out.last) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (!mode_q && !hit_q && !table_is_full) begin
						used_q <= used_q + cnft_pkg::USED_W'(1);
					end
					state_q <= ST_DONE;
				end
				ST_ZERO: begin
					iss_row_q <= iss_row_q + cnft_pkg::ROW_W'(1);
					if (iss_row_q == last_row_q) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// ---- operands and results ----
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q      <= push_win;
			tgt_q      <= in_idx;
			mode_q     <= (in_func == cnft_pkg::FUNC_READ);
			last_row_q <= (in_func == cnft_pkg::FUNC_READ) ?
				in_idx[cnft_pkg::INDEX_W-1:cnft_pkg::CELL_W] : used_last_row;
			hit_idx_q  <= '0;
			hit_key_q  <= '0;
			hit_cnt_q  <= '0;
			// default result; lookups overwrite it once decided
			res_flags_q <= '0;
			res_fi_q    <= (in_func == cnft_pkg::FUNC_READ) ? in_idx : '0;
			res_cnt_q   <= '0;
			res_bytes_q <= (in_func == cnft_pkg::FUNC_PUSH) ? push_win : '0;
		end
		if (chain_out.valid && chain_out.hit) begin
			hit_idx_q <= chain_out.hit_idx;
			hit_key_q <= chain_out.hit_key;
			hit_cnt_q <= chain_out.hit_cnt;
		end
		if (state_q == ST_DECIDE) begin
			if (mode_q) begin
				res_cnt_q   <= hit_cnt_q;
				res_bytes_q <= hit_key_q;
			end else if (hit_q) begin
				res_flags_q <= cnft_pkg::M_TUSER_W'(1 << cnft_pkg::FLAG_WF);
				res_fi_q    <= hit_idx_q;
				res_cnt_q   <= inc_cnt;
			end else if (!table_is_full) begin
				res_flags_q <= cnft_pkg::M_TUSER_W'((1 << cnft_pkg::FLAG_WF) |
				                                    (1 << cnft_pkg::FLAG_NEW));
				res_fi_q    <= used_q[cnft_pkg::INDEX_W-1:0];
				res_cnt_q   <= cnft_pkg::COUNT_BITS'(1);
			end else begin
				res_flags_q <= cnft_pkg::M_TUSER_W'(1 << cnft_pkg::FLAG_TF);
			end
		end
		if ((state_q == ST_DONE) && out_free) begin
			out_flags_q <= res_flags_q;
			out_fi_q    <= res_fi_q;
			out_cnt_q   <= res_cnt_q;
			out_bytes_q <= res_bytes_q;
			out_used_q  <= used_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_flags_q;
	assign m_axis_tdata  = cnft_pkg::M_TDATA_W'({out_used_q, out_bytes_q, out_cnt_q, out_fi_q});

endmodule

// ===== hdl/cnft_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cnft_checker
// Port-level checks of the n-gram frequency table, bound to the top level.
// ----------------------------------------------------------------------------
module cnft_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_axis_tvalid,
	input logic                            s_axis_tready,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [cnft_pkg::M_TDATA_W-1:0]  m_axis_tdata,
	input logic [cnft_pkg::M_TUSER_W-1:0]  m_axis_tuser
);

	logic [cnft_pkg::INDEX_W-1:0] fi;
	logic [cnft_pkg::COUNT_BITS-1:0] cnt;
	logic [cnft_pkg::USED_W-1:0]  used;

	assign fi   = m_axis_tdata[cnft_pkg::FI_LSB +: cnft_pkg::INDEX_W];
	assign cnt  = m_axis_tdata[cnft_pkg::CNT_LSB +: cnft_pkg::COUNT_BITS];
	assign used = m_axis_tdata[cnft_pkg::USED_LSB +: cnft_pkg::USED_W];

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result word changed while stalled");

	// one word in flight: the input side closes right after an accept
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("second word accepted while one is in flight");

	// a new entry is the last one appended and starts at count one
	a_new_entry: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[cnft_pkg::FLAG_NEW] |->
			m_axis_tuser[cnft_pkg::FLAG_WF] && (cnt == cnft_pkg::COUNT_BITS'(1)) &&
			(cnft_pkg::USED_W'(fi) + cnft_pkg::USED_W'(1) == used))
		else $error("new entry result inconsistent");

	// a dropped n-gram only when the table is full, and it is not counted
	a_drop: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[cnft_pkg::FLAG_TF] |->
			!m_axis_tuser[cnft_pkg::FLAG_WF] && !m_axis_tuser[cnft_pkg::FLAG_NEW] &&
			(used == cnft_pkg::USED_W'(cnft_pkg::TABLE_DEPTH)))
		else $error("n-gram dropped with free entries");

endmodule

bind char_ngram_frequency_table_core cnft_checker u_cnft_checker (.*);
